// ----- src/bldd_pkg.sv -----
// Package: widths, reset values, register indexes and types for the brake light detector.
package bldd_pkg;

   localparam int HISTORY_DEPTH = 20;
   localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);
   localparam int HIST_CNT_W    = $clog2(HISTORY_DEPTH + 1);

   localparam int STEP_W     = 10;
   localparam int SPEED_W    = 18;
   localparam int ACC_W      = 24;
   localparam int ALPHA_W    = 17;
   localparam int WIN_W      = 10;
   localparam int THR_W      = 17;
   localparam int LATCH_W    = 16;
   localparam int STOP_W     = 17;
   localparam int CSR_W      = 24;
   localparam int CSR_ADDR_W = 3;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   localparam int MAG_W      = 28;
   localparam int DIV_CNT_W  = $clog2(MAG_W + 1);
   localparam int SUM_W      = WIN_W + 1;
   localparam int PROD_W     = 42;
   localparam int FRAC_W     = 16;

   localparam int MS_PER_S   = 1000;

   localparam logic [ALPHA_W-1:0]      ALPHA_ONE = ALPHA_W'(65536);
   localparam logic [PROD_W-1:0]       EMA_ROUND = PROD_W'(32768);
   localparam logic signed [ACC_W-1:0] ACC_MAX   = 24'sh7FFFFF;
   localparam logic signed [ACC_W-1:0] ACC_MIN   = 24'sh800000;

   localparam logic [CSR_ADDR_W-1:0] CSR_EMA_ALPHA      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_MS      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DROP_THRESHOLD = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LATCH_MS       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_STOP_SPEED     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_HARD_DECEL     = 3'd5;

   localparam logic [ALPHA_W-1:0]      RST_EMA_ALPHA      = ALPHA_W'(19661);
   localparam logic [WIN_W-1:0]        RST_WINDOW_MS      = WIN_W'(300);
   localparam logic [THR_W-1:0]        RST_DROP_THRESHOLD = THR_W'(1000);
   localparam logic [LATCH_W-1:0]      RST_LATCH_MS       = LATCH_W'(1000);
   localparam logic [STOP_W-1:0]       RST_STOP_SPEED     = STOP_W'(500);
   localparam logic signed [ACC_W-1:0] RST_HARD_DECEL     = -24'sd1000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_MUL,
      ST_ADD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [STEP_W-1:0]         step_ms;
      logic signed [SPEED_W-1:0] speed;
   } hist_entry_type;

endpackage

// ----- src/brake_light_decel_detector.sv -----
// Top level: brake light deceleration detector with history memory walk and serial divider.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | req_tdata: step_ms[9:0], speed[27:10]
//  rsp     | out | rsp_tvalid/tready    | rsp_tdata: brake_light[0], light_changed[1],
//          |     |                      |            drop_event[2], smooth_accel[26:3]
//  csr     | in  | csr_we               | csr_addr, csr_wdata
//
// One transaction at a time: accept, run (28 radix-2 divider steps plus exit check), multiply, add,
// done. The history walk runs beside the divider; with step_ms zero it alone sets the run.
// Reset is synchronous; history memory is not cleared, only entries written are walked.
// A stalled rsp holds its result while one more item runs; that item then waits in done
// and req_tready stays low until the held result is taken.
module brake_light_decel_detector (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bldd_pkg::REQ_DATA_W-1:0]  req_tdata,   // step_ms, speed
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bldd_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // brake_light, light_changed,
                                                         // drop_event, smooth_accel
   input  logic                             csr_we,
   input  logic [bldd_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [bldd_pkg::CSR_W-1:0]       csr_wdata
);
   import bldd_pkg::*;

   state_type state_ff, state_in;

   logic [ALPHA_W-1:0]      alpha_ff;
   logic [WIN_W-1:0]        window_ff;
   logic [THR_W-1:0]        thr_ff;
   logic [LATCH_W-1:0]      latch_ms_ff;
   logic [STOP_W-1:0]       stop_ff;
   logic signed [ACC_W-1:0] hard_ff;

   logic [HIST_IDX_W-1:0]     head_ff, head_in;
   logic [HIST_CNT_W-1:0]     count_ff, count_in;
   logic signed [SPEED_W-1:0] prev_speed_ff, prev_speed_in;
   logic signed [ACC_W-1:0]   accel_avg_ff, accel_avg_in;
   logic [LATCH_W-1:0]        latch_left_ff, latch_left_in;
   logic                      light_ff, light_in;

   logic [STEP_W-1:0]         dt_ff, dt_in;
   logic signed [SPEED_W-1:0] spd_ff, spd_in;
   logic                      neg_ff, neg_in;
   logic [MAG_W-1:0]          div_q_ff, div_q_in;
   logic [STEP_W-1:0]         div_rem_ff, div_rem_in;
   logic [DIV_CNT_W-1:0]      div_cnt_ff, div_cnt_in;

   logic [HIST_IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [HIST_CNT_W-1:0]     walk_left_ff, walk_left_in;
   logic                      rd_valid_ff, rd_valid_in;
   hist_entry_type            rd_data_ff;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic                      found_ff, found_in;
   logic signed [SPEED_W-1:0] past_ff, past_in;

   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   avg_new_ff, avg_new_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   hist_entry_type            mem [HISTORY_DEPTH];

   logic run_en, mul_en, add_en, done_en;
   logic accept, rsp_load, walk_fin, rd_issue, hit;

   hist_entry_type            in_entry;
   logic signed [SPEED_W:0]   diff;
   logic [SPEED_W:0]          diff_abs;
   logic [MAG_W-1:0]          mag;
   logic [HIST_CNT_W-1:0]     count_new;

   logic [STEP_W:0]           div_trial, div_sub;
   logic                      div_ge;

   logic [SUM_W-1:0]          sum_add;

   logic [ALPHA_W-1:0]        alpha_sat;
   logic signed [ACC_W-1:0]   raw;
   logic signed [ACC_W:0]     ema_diff;
   logic signed [PROD_W:0]    prod_full;
   logic signed [PROD_W-1:0]  avg_shift, acc;
   logic signed [PROD_W-FRAC_W-1:0] acc_hi;

   logic signed [SPEED_W+1:0] spd_diff, neg_thr;
   logic                      drop;
   logic [LATCH_W-1:0]        latch_dec, latch_new;
   logic                      stopped, hard, light_on, changed;

   assign accept   = req_tvalid & req_tready;
   assign rsp_load = done_en & (~rsp_valid_ff | rsp_tready);
   assign walk_fin = found_ff | ((walk_left_ff == '0) & ~rd_valid_ff);
   assign rd_issue = run_en & (walk_left_ff != '0) & ~found_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if ((div_cnt_ff == '0) && walk_fin) state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_ADD;
         ST_ADD:  state_in = ST_DONE;
         ST_DONE: begin
            if (~rsp_valid_ff | rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      run_en     = 1'b0;
      mul_en     = 1'b0;
      add_en     = 1'b0;
      done_en    = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_RUN:  run_en     = 1'b1;
         ST_MUL:  mul_en     = 1'b1;
         ST_ADD:  add_en     = 1'b1;
         ST_DONE: done_en    = 1'b1;
         default: req_tready = 1'b0;
      endcase
   end

   always_comb begin
      in_entry.step_ms = req_tdata[STEP_W-1:0];
      in_entry.speed   = req_tdata[STEP_W+SPEED_W-1:STEP_W];
      diff      = {in_entry.speed[SPEED_W-1], in_entry.speed}
                - {prev_speed_ff[SPEED_W-1], prev_speed_ff};
      diff_abs  = diff[SPEED_W] ? -diff : diff;
      mag       = MAG_W'(diff_abs[SPEED_W-1:0]) * MAG_W'(MS_PER_S);
      count_new = (count_ff < HIST_CNT_W'(HISTORY_DEPTH)) ? count_ff + 1'b1 : count_ff;

      div_trial = {div_rem_ff, div_q_ff[MAG_W-1]};
      div_sub   = div_trial - {1'b0, dt_ff};
      div_ge    = div_trial >= {1'b0, dt_ff};

      sum_add   = sum_ff + {1'b0, rd_data_ff.step_ms};
      hit       = run_en & rd_valid_ff & ~found_ff & (sum_add >= {1'b0, window_ff});

      alpha_sat = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
      if (dt_ff == '0) begin
         raw = '0;
      end else if (neg_ff) begin
         raw = (div_q_ff > MAG_W'(8388608)) ? ACC_MIN : -$signed(div_q_ff[ACC_W-1:0]);
      end else begin
         raw = (div_q_ff > MAG_W'(8388607)) ? ACC_MAX : $signed(div_q_ff[ACC_W-1:0]);
      end
      ema_diff  = {raw[ACC_W-1], raw} - {accel_avg_ff[ACC_W-1], accel_avg_ff};
      prod_full = $signed({1'b0, alpha_sat}) * ema_diff;

      avg_shift = {{(PROD_W-ACC_W-FRAC_W){accel_avg_ff[ACC_W-1]}}, accel_avg_ff,
                   {FRAC_W{1'b0}}};
      acc       = avg_shift + prod_ff + $signed(EMA_ROUND);
      acc_hi    = acc[PROD_W-1:FRAC_W];

      spd_diff  = {{2{spd_ff[SPEED_W-1]}}, spd_ff} - {{2{past_ff[SPEED_W-1]}}, past_ff};
      neg_thr   = -$signed({3'b000, thr_ff});
      drop      = found_ff & (spd_diff < neg_thr);
      latch_dec = (latch_left_ff > LATCH_W'(dt_ff)) ? latch_left_ff - LATCH_W'(dt_ff) : '0;
      latch_new = drop ? latch_ms_ff : latch_dec;
      stopped   = $signed({spd_ff[SPEED_W-1], spd_ff}) < $signed({2'b00, stop_ff});
      hard      = avg_new_ff < hard_ff;
      light_on  = stopped | (latch_new != '0) | hard;
      changed   = light_on ^ light_ff;
   end

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      prev_speed_in = prev_speed_ff;
      accel_avg_in  = accel_avg_ff;
      latch_left_in = latch_left_ff;
      light_in      = light_ff;
      dt_in         = dt_ff;
      spd_in        = spd_ff;
      neg_in        = neg_ff;
      div_q_in      = div_q_ff;
      div_rem_in    = div_rem_ff;
      div_cnt_in    = div_cnt_ff;
      rd_idx_in     = rd_idx_ff;
      walk_left_in  = walk_left_ff;
      rd_valid_in   = rd_issue;
      sum_in        = sum_ff;
      found_in      = found_ff;
      past_in       = past_ff;
      prod_in       = prod_ff;
      avg_new_in    = avg_new_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (accept) begin
         head_in      = (head_ff == HIST_IDX_W'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in     = count_new;
         dt_in        = in_entry.step_ms;
         spd_in       = in_entry.speed;
         neg_in       = diff[SPEED_W];
         div_q_in     = mag;
         div_rem_in   = '0;
         div_cnt_in   = (in_entry.step_ms == '0) ? '0 : DIV_CNT_W'(MAG_W);
         rd_idx_in    = head_ff;
         walk_left_in = count_new;
         sum_in       = '0;
         found_in     = 1'b0;
      end

      if (run_en && (div_cnt_ff != '0)) begin
         div_q_in   = {div_q_ff[MAG_W-2:0], div_ge};
         div_rem_in = div_ge ? div_sub[STEP_W-1:0] : div_trial[STEP_W-1:0];
         div_cnt_in = div_cnt_ff - 1'b1;
      end

      if (rd_issue) begin
         rd_idx_in    = (rd_idx_ff == '0) ? HIST_IDX_W'(HISTORY_DEPTH - 1) : rd_idx_ff - 1'b1;
         walk_left_in = walk_left_ff - 1'b1;
      end

      if (run_en && rd_valid_ff && !found_ff) begin
         sum_in = sum_add;
      end
      if (hit) begin
         found_in = 1'b1;
         past_in  = rd_data_ff.speed;
      end

      if (mul_en) begin
         prod_in = prod_full[PROD_W-1:0];
      end

      if (add_en) begin
         if (acc_hi[PROD_W-FRAC_W-1:ACC_W-1] != '0 && acc_hi[PROD_W-FRAC_W-1:ACC_W-1] != '1) begin
            avg_new_in = acc_hi[PROD_W-FRAC_W-1] ? ACC_MIN : ACC_MAX;
         end else begin
            avg_new_in = acc_hi[ACC_W-1:0];
         end
      end

      if (rsp_load) begin
         prev_speed_in = spd_ff;
         accel_avg_in  = avg_new_ff;
         latch_left_in = latch_new;
         light_in      = light_on;
         rsp_valid_in  = 1'b1;
         rsp_data_in   = {{(RSP_DATA_W-ACC_W-3){1'b0}}, avg_new_ff, drop, changed, light_on};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) mem[head_ff] <= in_entry;
      if (rd_issue) rd_data_ff <= mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         alpha_ff      <= RST_EMA_ALPHA;
         window_ff     <= RST_WINDOW_MS;
         thr_ff        <= RST_DROP_THRESHOLD;
         latch_ms_ff   <= RST_LATCH_MS;
         stop_ff       <= RST_STOP_SPEED;
         hard_ff       <= RST_HARD_DECEL;
         head_ff       <= '0;
         count_ff      <= '0;
         prev_speed_ff <= '0;
         accel_avg_ff  <= '0;
         latch_left_ff <= '0;
         light_ff      <= 1'b0;
         div_cnt_ff    <= '0;
         walk_left_ff  <= '0;
         rd_valid_ff   <= 1'b0;
         found_ff      <= 1'b0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         prev_speed_ff <= prev_speed_in;
         accel_avg_ff  <= accel_avg_in;
         latch_left_ff <= latch_left_in;
         light_ff      <= light_in;
         div_cnt_ff    <= div_cnt_in;
         walk_left_ff  <= walk_left_in;
         rd_valid_ff   <= rd_valid_in;
         found_ff      <= found_in;
         sum_ff        <= sum_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_EMA_ALPHA:      alpha_ff    <= csr_wdata[ALPHA_W-1:0];
               CSR_WINDOW_MS:      window_ff   <= csr_wdata[WIN_W-1:0];
               CSR_DROP_THRESHOLD: thr_ff      <= csr_wdata[THR_W-1:0];
               CSR_LATCH_MS:       latch_ms_ff <= csr_wdata[LATCH_W-1:0];
               CSR_STOP_SPEED:     stop_ff     <= csr_wdata[STOP_W-1:0];
               CSR_HARD_DECEL:     hard_ff     <= csr_wdata[ACC_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      dt_ff       <= dt_in;
      spd_ff      <= spd_in;
      neg_ff      <= neg_in;
      div_q_ff    <= div_q_in;
      div_rem_ff  <= div_rem_in;
      rd_idx_ff   <= rd_idx_in;
      past_ff     <= past_in;
      prod_ff     <= prod_in;
      avg_new_ff  <= avg_new_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_accept_to_run: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_RUN))
      else $error("accepted transaction did not start the run phase");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= HIST_CNT_W'(HISTORY_DEPTH))
      else $error("history count beyond depth");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (div_cnt_ff == '0))
      else $error("multiply started before divide finished");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside done state");

   a_sum_window: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && !found_ff) |-> (sum_ff <= {1'b0, window_ff}))
      else $error("window sum passed window without a hit");

endmodule
